FILE: rtl/sdoc_pkg.sv
`default_nettype none

package sdoc_pkg;

  // buffer cap of a segmented read
  localparam logic [15:0] MAX_BUFFER_BYTES = 16'd65535;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;

  // item kinds
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_EXP_RD   = 3'd1;
  localparam logic [2:0] OP_EXP_WR   = 3'd2;
  localparam logic [2:0] OP_SEG_RD   = 3'd3;
  localparam logic [2:0] OP_RX_FRAME = 3'd4;

  // transfer state codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_OK     = 3'd1;
  localparam logic [2:0] ST_EXP_RD = 3'd2;
  localparam logic [2:0] ST_EXP_WR = 3'd3;
  localparam logic [2:0] ST_SEG_RD = 3'd4;

  // register indexes
  localparam logic [1:0] CFG_CLIENT_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_MS    = 2'd1;

  // sdo command bytes and fields
  localparam logic [7:0] CMD_ABORT          = 8'h80;
  localparam logic [7:0] CMD_UPLOAD_INIT    = 8'h40;
  localparam logic [7:0] CMD_DOWNLOAD_RESP  = 8'h60;
  localparam logic [7:0] CMD_SEG_ACK        = 8'h60;
  localparam logic [2:0] CMD_EXP_DL_PREFIX  = 3'b001;
  localparam logic [2:0] SCS_UPLOAD_INIT    = 3'b010;
  localparam logic [2:0] SCS_UPLOAD_SEG     = 3'b000;

  typedef struct packed {
    logic [2:0]  op;
    logic        tx_ready;
    logic [6:0]  node_id;
    logic [15:0] object_index;
    logic [7:0]  object_subindex;
    logic [31:0] write_value;
    logic [2:0]  write_length;
    logic [15:0] buffer_size;
    logic [63:0] rx_frame;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [6:0]  tx_node;
    logic [63:0] tx_frame;
    logic        start_accepted;
    logic [2:0]  transfer_status;
    logic [31:0] abort_word;
    logic [2:0]  data_count;
    logic [15:0] data_offset;
    logic [55:0] data_bytes;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/sdoc_in_stage.sv
`default_nettype none

module sdoc_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire sdoc_pkg::item_t item_i,
  input  wire                 advance_i,
  output logic                item_valid_o,
  output sdoc_pkg::item_t     item_o
);
  import sdoc_pkg::*;

  logic  valid_q;
  item_t item_q;

  // take a new beat when empty or when the held one moves on
  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sdoc_step.sv
`default_nettype none

module sdoc_step (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_write_i,
  input  wire  [1:0]          cfg_index_i,
  input  wire  [15:0]         cfg_data_i,
  input  wire                 advance_i,
  input  wire sdoc_pkg::item_t item_i,
  output sdoc_pkg::result_t   result_o
);
  import sdoc_pkg::*;

  // configuration
  logic        enable_q;
  logic [15:0] timeout_q;

  // transfer state
  logic [2:0]  state_q, state_d;
  logic [15:0] tleft_q, tleft_d;
  logic [31:0] abort_q, abort_d;
  logic [15:0] fill_q, fill_d;
  logic [15:0] limit_q, limit_d;
  logic [6:0]  seg_node_q, seg_node_d;

  logic        busy;
  logic        start_ok;
  logic        send;
  logic        abort_hit;
  logic [2:0]  cur_state;
  logic [7:0]  b0;
  logic [2:0]  exp_n;
  logic [2:0]  seg_n;
  logic [16:0] room_full;
  logic [2:0]  room;
  logic [2:0]  stored;
  logic [1:0]  wr_gap;
  result_t     res;

  function automatic logic [55:0] byte_mask(input logic [2:0] count);
    logic [55:0] m;
    m = '0;
    for (int i = 0; i < 7; i++) begin
      m[8*i +: 8] = {8{3'(i) < count}};
    end
    return m;
  endfunction

  function automatic logic [63:0] init_frame(input logic [7:0]  cmd,
                                             input logic [15:0] idx,
                                             input logic [7:0]  sub,
                                             input logic [31:0] val);
    return {val, sub, idx, cmd};
  endfunction

  assign busy   = (state_q == ST_EXP_RD) || (state_q == ST_EXP_WR) ||
                  (state_q == ST_SEG_RD);
  assign b0     = item_i.rx_frame[7:0];
  assign exp_n  = 3'd4 - {1'b0, b0[3:2]};
  assign seg_n  = 3'd7 - b0[3:1];
  assign wr_gap = 2'(3'd4 - item_i.write_length);

  // free room in the receive buffer, clamped to one segment
  assign room_full = {1'b0, limit_q} - {1'b0, fill_q};
  always_comb begin
    if (fill_q >= limit_q) begin
      room = 3'd0;
    end else if (room_full > 17'd7) begin
      room = 3'd7;
    end else begin
      room = room_full[2:0];
    end
  end
  assign stored = (seg_n < room) ? seg_n : room;

  // next state and result for one item
  always_comb begin
    state_d    = state_q;
    tleft_d    = tleft_q;
    abort_d    = abort_q;
    fill_d     = fill_q;
    limit_d    = limit_q;
    seg_node_d = seg_node_q;
    res        = '0;
    start_ok   = enable_q && item_i.tx_ready && !busy;
    send       = 1'b0;
    abort_hit  = (b0 == CMD_ABORT);
    cur_state  = abort_hit ? ST_IDLE : state_q;

    case (item_i.op) inside
      OP_TICK: begin
        if (busy && (tleft_q != 16'd0)) begin
          tleft_d = tleft_q - 16'd1;
          if (tleft_q == 16'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      OP_EXP_RD, OP_EXP_WR, OP_SEG_RD: begin
        if (start_ok) begin
          case (item_i.op)
            OP_EXP_RD: begin
              state_d      = ST_EXP_RD;
              fill_d       = 16'd0;
              send         = 1'b1;
              res.tx_frame = init_frame(CMD_UPLOAD_INIT, item_i.object_index,
                                        item_i.object_subindex, 32'd0);
            end
            OP_EXP_WR: begin
              if ((item_i.write_length == 3'd0) || (item_i.write_length > 3'd4)) begin
                state_d = ST_IDLE;
              end else begin
                state_d      = ST_EXP_WR;
                send         = 1'b1;
                res.tx_frame = init_frame({CMD_EXP_DL_PREFIX, 1'b0, wr_gap, 2'b11},
                                          item_i.object_index, item_i.object_subindex,
                                          item_i.write_value);
              end
            end
            default: begin
              state_d      = ST_SEG_RD;
              limit_d      = (item_i.buffer_size > MAX_BUFFER_BYTES) ?
                             MAX_BUFFER_BYTES : item_i.buffer_size;
              seg_node_d   = item_i.node_id;
              send         = 1'b1;
              res.tx_frame = init_frame(CMD_UPLOAD_INIT, item_i.object_index,
                                        item_i.object_subindex, 32'd0);
            end
          endcase
          if (send) begin
            tleft_d            = timeout_q;
            res.tx_valid       = 1'b1;
            res.tx_node        = item_i.node_id;
            res.start_accepted = 1'b1;
          end
        end
      end
      OP_RX_FRAME: begin
        if (abort_hit) begin
          state_d = ST_IDLE;
          abort_d = item_i.rx_frame[63:32];
        end
        case (cur_state)
          ST_EXP_RD: begin
            if (b0[7:5] == SCS_UPLOAD_INIT) begin
              fill_d         = {13'd0, exp_n};
              res.data_count = exp_n;
              res.data_bytes = {24'd0, item_i.rx_frame[63:32]} & byte_mask(exp_n);
              state_d        = ST_OK;
            end
          end
          ST_EXP_WR: begin
            if (b0 == CMD_DOWNLOAD_RESP) begin
              state_d = ST_OK;
            end
          end
          ST_SEG_RD: begin
            if ((b0[7:5] == SCS_UPLOAD_INIT) && !b0[1]) begin
              // initiate reply: acknowledge first segment request
              res.tx_valid = 1'b1;
              res.tx_node  = seg_node_q;
              res.tx_frame = {56'd0, CMD_SEG_ACK};
              fill_d       = 16'd0;
            end else if (b0[7:5] == SCS_UPLOAD_SEG) begin
              res.data_count  = stored;
              res.data_offset = (stored != 3'd0) ? fill_q : 16'd0;
              res.data_bytes  = item_i.rx_frame[63:8] & byte_mask(stored);
              fill_d          = fill_q + {13'd0, stored};
              if (seg_n > stored) begin
                // overflow fails the transfer, no acknowledge
                state_d = ST_IDLE;
              end else if (b0[0]) begin
                state_d = ST_OK;
              end else begin
                res.tx_valid = 1'b1;
                res.tx_node  = seg_node_q;
                res.tx_frame = {56'd0, CMD_SEG_ACK[7:5], ~b0[4], CMD_SEG_ACK[3:0]};
              end
              tleft_d = timeout_q;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res.transfer_status = state_d;
    res.abort_word      = abort_d;
  end

  assign result_o = res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CFG_CLIENT_ENABLE: enable_q  <= cfg_data_i[0];
        CFG_TIMEOUT_MS:    timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // transfer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tleft_q    <= 16'd0;
      abort_q    <= 32'd0;
      fill_q     <= 16'd0;
      limit_q    <= 16'd0;
      seg_node_q <= 7'd0;
    end else if (advance_i) begin
      state_q    <= state_d;
      tleft_q    <= tleft_d;
      abort_q    <= abort_d;
      fill_q     <= fill_d;
      limit_q    <= limit_d;
      seg_node_q <= seg_node_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sdoc_out_stage.sv
`default_nettype none

module sdoc_out_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  wire sdoc_pkg::result_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output sdoc_pkg::result_t   result_o
);
  import sdoc_pkg::*;

  logic    valid_q;
  result_t result_q;

  // room for a new result when empty or when the held one leaves now
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sdo_client_transfer_engine_core.sv
`default_nettype none

// SDO client transfer engine: builds expedited read/write and segmented
// upload request frames, decodes server replies and aborts, and reports
// received data bytes with their buffer offset. Every input beat yields one
// result beat. A beat is taken into an input register, decoded combinationally against the
// transfer state and lands in a result register, so the block sustains one item per clock
// while the output side takes results;
// the result register alone throttles it when the output side stalls.
// Configuration writes are taken every cycle and land in the configuration registers.
module sdo_client_transfer_engine_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  // configuration
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [1:0]   cfg_index_i,
  input  wire  [15:0]  cfg_data_i,
  // input beats
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [2:0]   op_i,
  input  wire          tx_ready_i,
  input  wire  [6:0]   node_id_i,
  input  wire  [15:0]  object_index_i,
  input  wire  [7:0]   object_subindex_i,
  input  wire  [31:0]  write_value_i,
  input  wire  [2:0]   write_length_i,
  input  wire  [15:0]  buffer_size_i,
  input  wire  [63:0]  rx_frame_i,
  // result beats
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic         tx_valid_o,
  output logic [6:0]   tx_node_o,
  output logic [63:0]  tx_frame_o,
  output logic         start_accepted_o,
  output logic [2:0]   transfer_status_o,
  output logic [31:0]  abort_word_o,
  output logic [2:0]   data_count_o,
  output logic [15:0]  data_offset_o,
  output logic [55:0]  data_bytes_o
);
  import sdoc_pkg::*;

  item_t   item_in;
  item_t   item_held;
  logic    item_valid;
  logic    out_free;
  logic    advance;
  result_t step_res;
  result_t out_res;

  assign cfg_ready_o = 1'b1;

  assign item_in = '{op:              op_i,
                     tx_ready:        tx_ready_i,
                     node_id:         node_id_i,
                     object_index:    object_index_i,
                     object_subindex: object_subindex_i,
                     write_value:     write_value_i,
                     write_length:    write_length_i,
                     buffer_size:     buffer_size_i,
                     rx_frame:        rx_frame_i};

  // a held beat moves on when the result register has room
  assign advance = item_valid && out_free;

  sdoc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item_in),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item_held)
  );

  sdoc_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .item_i      (item_held),
    .result_o    (step_res)
  );

  sdoc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign tx_valid_o        = out_res.tx_valid;
  assign tx_node_o         = out_res.tx_node;
  assign tx_frame_o        = out_res.tx_frame;
  assign start_accepted_o  = out_res.start_accepted;
  assign transfer_status_o = out_res.transfer_status;
  assign abort_word_o      = out_res.abort_word;
  assign data_count_o      = out_res.data_count;
  assign data_offset_o     = out_res.data_offset;
  assign data_bytes_o      = out_res.data_bytes;

`ifndef NO_ASSERTIONS
  // an accepted start always leaves a busy transfer and sends its frame
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_accepted_o |->
      tx_valid_o && ((transfer_status_o == ST_EXP_RD) ||
                     (transfer_status_o == ST_EXP_WR) ||
                     (transfer_status_o == ST_SEG_RD)))
    else $error("start accepted without busy transfer");

  // no reported bytes means clean data fields
  a_no_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (data_count_o == 3'd0) |->
      (data_bytes_o == 56'd0) && (data_offset_o == 16'd0))
    else $error("data fields set with zero count");

  // no frame sent means clean frame fields
  a_no_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> (tx_frame_o == 64'd0) && (tx_node_o == 7'd0))
    else $error("frame fields set without tx_valid");

  // a beat taken into an empty input register is held there next cycle
  a_beat_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !item_valid |=> item_valid)
    else $error("input beat lost");
`endif

endmodule

`default_nettype wire
